// ===== hw/rtl/cfd_pkg.sv =====
`default_nettype none
package cfd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SIZE_W    = 31;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_CHARGE   = 2'd0,
    CFG_MOLECULE_SIZE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential;
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
  } out_t;

  localparam logic signed [DATA_W-1:0] UNIT_CHARGE_RST = 32'sd65536;
  localparam logic [SIZE_W-1:0]        SIZE_RST        = 31'd65536;

  // floor distance = size / 500 through a reciprocal, exact for 31-bit sizes
  localparam int unsigned        RMIN_W     = 23;
  localparam logic [RMIN_W-1:0]  RMIN_RST   = 23'd131;
  localparam logic [31:0]        RMIN_RECIP = 32'd2199023256;
  localparam int unsigned        RMIN_SHIFT = 40;

  localparam int unsigned R_W    = 33;  // distance, Q16.16
  localparam int unsigned MAG_W  = 32;  // coordinate difference magnitude
  localparam int unsigned U_NW   = 62;  // |d| << 30
  localparam int unsigned W_NW   = 64;
  localparam int unsigned POT_W  = 50;  // one potential term
  localparam int unsigned FLD_W  = 63;  // one field term
  localparam int unsigned SIDE_W = 3 + 3 * MAG_W;
  localparam int unsigned SUM_W  = 66;

  localparam logic [W_NW-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

  localparam logic signed [SUM_W-1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/three_charge_coulomb_field_top.sv =====
// throughput: one point per cycle unless in_stall_o is high, set by the fully
// pipelined square root and the three chained dividers per charge (62, 64 and
// 64 stages).
// reset: pipeline and output valids cleared, unit_charge = 1.0,
// molecule_size = 1.0.
`default_nettype none
module three_charge_coulomb_field_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire cfd_pkg::in_t                        in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output cfd_pkg::out_t                            out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [cfd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [cfd_pkg::DATA_W-1:0]          cfg_data_i
);
  import cfd_pkg::*;

  // configuration
  logic signed [DATA_W-1:0] charge_q;
  logic [SIZE_W-1:0]        size_q;
  logic [RMIN_W-1:0]        rmin_q;
  logic [62:0]              rmin_prod;
  logic [RMIN_W-1:0]        rmin_est;
  logic [RMIN_W-1:0]        rmin_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_q <= UNIT_CHARGE_RST;
      size_q   <= SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UNIT_CHARGE:   charge_q <= cfg_data_i;
        CFG_MOLECULE_SIZE: size_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign rmin_prod = size_q * RMIN_RECIP;
  assign rmin_est  = rmin_prod[RMIN_SHIFT +: RMIN_W];
  assign rmin_d    = (rmin_est == '0) ? RMIN_W'(1) : rmin_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q <= RMIN_RST;
    end else begin
      rmin_q <= rmin_d;
    end
  end

  // charge positions
  logic signed [DATA_W-1:0] ctr;
  logic signed [DATA_W-1:0] off;
  logic signed [DATA_W-1:0] cx [3];
  assign ctr   = {1'b0, size_q[SIZE_W-1:1]};
  assign off   = {3'b000, size_q[SIZE_W-1:3]};
  assign cx[0] = ctr;
  assign cx[1] = ctr - off;
  assign cx[2] = ctr + off;

  // whole pipeline moves unless the skid slot is holding a result
  logic skid_vld_q;
  logic en;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  logic                               ch_vld;
  logic signed [POT_W-1:0]            pot [3];
  logic [2:0][FLD_W-1:0]              fld [3];

  for (genvar c = 0; c < 3; c++) begin : g_charge
    if (c == 0) begin : g_lead
      cfd_charge u_charge (
        .clk_i, .rst_ni,
        .en_i     (en),
        .vld_i    (in_valid_i),
        .pos_i    (in_data_i),
        .cx_i     (cx[c]),
        .cy_i     (ctr),
        .q_i      (charge_q),
        .rmin_i   (rmin_q),
        .centre_i (1'b1),
        .vld_o    (ch_vld),
        .pot_o    (pot[c]),
        .fld_o    (fld[c])
      );
    end else begin : g_outer
      cfd_charge u_charge (
        .clk_i, .rst_ni,
        .en_i     (en),
        .vld_i    (in_valid_i),
        .pos_i    (in_data_i),
        .cx_i     (cx[c]),
        .cy_i     (ctr),
        .q_i      (charge_q),
        .rmin_i   (rmin_q),
        .centre_i (1'b0),
        .vld_o    (),
        .pot_o    (pot[c]),
        .fld_o    (fld[c])
      );
    end
  end

  // sum the three charges and saturate
  logic signed [SUM_W-1:0] pot_sum;
  logic signed [SUM_W-1:0] fld_sum [3];
  assign pot_sum = SUM_W'(pot[0]) + SUM_W'(pot[1]) + SUM_W'(pot[2]);
  for (genvar j = 0; j < 3; j++) begin : g_fsum
    assign fld_sum[j] = SUM_W'($signed(fld[0][j])) + SUM_W'($signed(fld[1][j]))
                      + SUM_W'($signed(fld[2][j]));
  end

  logic sum_vld_q;
  out_t sum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en) begin
      sum_vld_q <= ch_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q.potential <= sat32(pot_sum);
      sum_q.field_x   <= sat32(fld_sum[0]);
      sum_q.field_y   <= sat32(fld_sum[1]);
      sum_q.field_z   <= sat32(fld_sum[2]);
    end
  end

  // output register with one skid slot
  logic out_vld_q;
  out_t out_q;
  out_t skid_q;
  logic out_free;
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (sum_vld_q) begin
      if (out_free) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_free) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (sum_vld_q) begin
      if (out_free) begin
        out_q <= sum_q;
      end else begin
        skid_q <= sum_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled while output slot was free");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a result with empty output slot");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> (!skid_vld_q && out_vld_q))
    else $error("skid did not drain into output slot");

  a_rmin_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmin_q != '0)
    else $error("distance floor is zero");

endmodule
`default_nettype wire

// ===== hw/rtl/cfd_div.sv =====
`default_nettype none
module cfd_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      den_o,
  output logic [SW-1:0]      side_o
);

  // restoring division, one quotient bit per stage
  logic [NW-1:0] vld_q;
  logic [NW-1:0] vld_in;
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic [DW-1:0] rem_in  [NW];
  logic [NW-1:0] quo_in  [NW];
  logic [DW-1:0] den_in  [NW];
  logic [SW-1:0] side_in [NW];
  logic [DW:0]   trial   [NW];
  logic [NW-1:0] ge;
  logic [DW-1:0] rem_d   [NW];
  logic [NW-1:0] quo_d   [NW];

  assign vld_in = {vld_q[NW-2:0], vld_i};

  for (genvar i = 0; i < NW; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign rem_in[i]  = '0;
      assign quo_in[i]  = num_i;
      assign den_in[i]  = den_i;
      assign side_in[i] = side_i;
    end else begin : g_next
      assign rem_in[i]  = rem_q[i-1];
      assign quo_in[i]  = quo_q[i-1];
      assign den_in[i]  = den_q[i-1];
      assign side_in[i] = side_q[i-1];
    end
    assign trial[i] = {rem_in[i], quo_in[i][NW-1]};
    assign ge[i]    = trial[i] >= {1'b0, den_in[i]};
    assign rem_d[i] = ge[i] ? DW'(trial[i] - {1'b0, den_in[i]}) : trial[i][DW-1:0];
    assign quo_d[i] = {quo_in[i][NW-2:0], ge[i]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NW; i++) begin
        rem_q[i]  <= rem_d[i];
        quo_q[i]  <= quo_d[i];
        den_q[i]  <= den_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = quo_q[NW-1];
  assign den_o  = den_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/cfd_sqrt.sv =====
`default_nettype none
module cfd_sqrt #(
  parameter int unsigned RW = 33,
  parameter int unsigned SW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 vld_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);

  // digit-by-digit square root, one root bit per stage, msb first
  logic [RW-1:0]   vld_q;
  logic [RW-1:0]   vld_in;
  logic [2*RW-1:0] rem_q  [RW];
  logic [RW-1:0]   res_q  [RW];
  logic [SW-1:0]   side_q [RW];

  logic [2*RW-1:0] rem_in  [RW];
  logic [RW-1:0]   res_in  [RW];
  logic [SW-1:0]   side_in [RW];
  logic [2*RW:0]   trial   [RW];
  logic [RW-1:0]   ge;
  logic [2*RW-1:0] rem_d   [RW];
  logic [RW-1:0]   res_d   [RW];

  assign vld_in = {vld_q[RW-2:0], vld_i};

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int unsigned B = RW - 1 - i;
    if (i == 0) begin : g_first
      assign rem_in[i]  = rad_i;
      assign res_in[i]  = '0;
      assign side_in[i] = side_i;
    end else begin : g_next
      assign rem_in[i]  = rem_q[i-1];
      assign res_in[i]  = res_q[i-1];
      assign side_in[i] = side_q[i-1];
    end
    // (res + 2^b)^2 - res^2
    assign trial[i] = ({{(RW+1){1'b0}}, res_in[i]} << (B + 1))
                    + ((2*RW+1)'(1) << (2 * B));
    assign ge[i]    = {1'b0, rem_in[i]} >= trial[i];
    assign rem_d[i] = ge[i] ? (2*RW)'({1'b0, rem_in[i]} - trial[i]) : rem_in[i];
    assign res_d[i] = ge[i] ? (res_in[i] | (RW'(1) << B)) : res_in[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RW; i++) begin
        rem_q[i]  <= rem_d[i];
        res_q[i]  <= res_d[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = res_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/cfd_charge.sv =====
`default_nettype none
module cfd_charge (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               vld_i,
  input  wire cfd_pkg::in_t                       pos_i,
  input  wire logic signed [cfd_pkg::DATA_W-1:0]  cx_i,
  input  wire logic signed [cfd_pkg::DATA_W-1:0]  cy_i,
  input  wire logic signed [cfd_pkg::DATA_W-1:0]  q_i,
  input  wire logic [cfd_pkg::RMIN_W-1:0]         rmin_i,
  input  wire logic                               centre_i,
  output logic                                    vld_o,
  output logic signed [cfd_pkg::POT_W-1:0]        pot_o,
  output logic [2:0][cfd_pkg::FLD_W-1:0]          fld_o
);
  import cfd_pkg::*;

  logic [MAG_W-1:0] q_mag;
  assign q_mag = q_i[DATA_W-1] ? MAG_W'(-q_i) : q_i;

  // coordinate differences
  logic                   s1_vld_q;
  logic [2:0][MAG_W:0]    d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= {pos_i.pos_x[DATA_W-1], pos_i.pos_x} - {cx_i[DATA_W-1], cx_i};
      d_q[1] <= {pos_i.pos_y[DATA_W-1], pos_i.pos_y} - {cy_i[DATA_W-1], cy_i};
      d_q[2] <= {pos_i.pos_z[DATA_W-1], pos_i.pos_z};
    end
  end

  // magnitudes and squares
  logic [2:0][MAG_W-1:0]   mag_d;
  logic                    s2_vld_q;
  logic [2:0][MAG_W-1:0]   mag2_q;
  logic [2:0]              neg2_q;
  logic [2:0][2*MAG_W-1:0] sq_q;
  for (genvar j = 0; j < 3; j++) begin : g_mag
    assign mag_d[j] = d_q[j][MAG_W] ? MAG_W'(-d_q[j]) : d_q[j][MAG_W-1:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        mag2_q[j] <= mag_d[j];
        neg2_q[j] <= d_q[j][MAG_W];
        sq_q[j]   <= mag_d[j] * mag_d[j];
      end
    end
  end

  // sum of squares
  logic                    s3_vld_q;
  logic [2*R_W-1:0]        ssum_q;
  logic [SIDE_W-1:0]       side3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ssum_q  <= (2*R_W)'(sq_q[0]) + (2*R_W)'(sq_q[1]) + (2*R_W)'(sq_q[2]);
      side3_q <= {neg2_q, mag2_q};
    end
  end

  logic              sq_vld;
  logic [R_W-1:0]    root;
  logic [SIDE_W-1:0] sq_side;
  cfd_sqrt #(.RW(R_W), .SW(SIDE_W)) u_sqrt (
    .clk_i, .rst_ni, .en_i,
    .vld_i  (s3_vld_q),
    .rad_i  (ssum_q),
    .side_i (side3_q),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // distance floor
  logic                  fl_vld_q;
  logic [R_W-1:0]        r_q;
  logic [2:0]            neg_fl_q;
  logic [2:0][MAG_W-1:0] mag_fl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_vld_q <= 1'b0;
    end else if (en_i) begin
      fl_vld_q <= sq_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q      <= (root > R_W'(rmin_i)) ? root : R_W'(rmin_i);
      {neg_fl_q, mag_fl_q} <= sq_side;
    end
  end

  // u = (|d| << 30) / r
  logic [2:0]           b1_vld;
  logic [2:0][U_NW-1:0] u;
  logic [2:0][R_W-1:0]  r1;
  logic [2:0]           neg1;
  for (genvar j = 0; j < 3; j++) begin : g_udiv
    cfd_div #(.NW(U_NW), .DW(R_W), .SW(1)) u_div (
      .clk_i, .rst_ni, .en_i,
      .vld_i  (fl_vld_q),
      .num_i  ({mag_fl_q[j], 30'd0}),
      .den_i  (r_q),
      .side_i (neg_fl_q[j]),
      .vld_o  (b1_vld[j]),
      .quo_o  (u[j]),
      .den_o  (r1[j]),
      .side_o (neg1[j])
    );
  end

  // |q| * u, kept modulo 2^64 as two partial products
  logic                  mu_vld_q;
  logic [2:0][63:0]      lo_q;
  logic [2:0][31:0]      hi_q;
  logic [2:0][R_W-1:0]   r_mu_q;
  logic [2:0]            neg_mu_q;
  logic [2:0][63:0]      hi_full;
  for (genvar j = 0; j < 3; j++) begin : g_hi
    assign hi_full[j] = q_mag * {2'b00, u[j][U_NW-1:32]};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (en_i) begin
      mu_vld_q <= b1_vld[0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j]     <= q_mag * u[j][31:0];
        hi_q[j]     <= hi_full[j][31:0];
        r_mu_q[j]   <= r1[j];
        neg_mu_q[j] <= neg1[j];
      end
    end
  end

  logic                  ad_vld_q;
  logic [2:0][W_NW-1:0]  wn_q;
  logic [2:0][R_W-1:0]   r_ad_q;
  logic [2:0]            neg_ad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad_vld_q <= 1'b0;
    end else if (en_i) begin
      ad_vld_q <= mu_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        wn_q[j]     <= lo_q[j] + {hi_q[j], 32'd0};
        r_ad_q[j]   <= r_mu_q[j];
        neg_ad_q[j] <= neg_mu_q[j];
      end
    end
  end

  // w = (|q| * u) / r
  logic [2:0]           b2_vld;
  logic [2:0][W_NW-1:0] w;
  logic [2:0][R_W-1:0]  r2;
  logic [2:0]           neg2;
  for (genvar j = 0; j < 3; j++) begin : g_wdiv
    cfd_div #(.NW(W_NW), .DW(R_W), .SW(1)) u_div (
      .clk_i, .rst_ni, .en_i,
      .vld_i  (ad_vld_q),
      .num_i  (wn_q[j]),
      .den_i  (r_ad_q[j]),
      .side_i (neg_ad_q[j]),
      .vld_o  (b2_vld[j]),
      .quo_o  (w[j]),
      .den_o  (r2[j]),
      .side_o (neg2[j])
    );
  end

  // m = 4w / r, and the potential quotient alongside
  logic [2:0][W_NW-1:0] m;
  logic [2:0]           neg3;
  logic                 b3_vld;
  logic [W_NW-1:0]      pot_quo;
  logic                 pot_neg;
  logic [W_NW-1:0]      pot_num;
  assign pot_num = centre_i ? (W_NW'(q_mag) << 17) : (W_NW'(q_mag) << 16);

  for (genvar j = 0; j < 3; j++) begin : g_mdiv
    if (j == 0) begin : g_lead
      cfd_div #(.NW(W_NW), .DW(R_W), .SW(1)) u_div (
        .clk_i, .rst_ni, .en_i,
        .vld_i  (b2_vld[0]),
        .num_i  ({w[j][W_NW-3:0], 2'b00}),
        .den_i  (r2[j]),
        .side_i (neg2[j]),
        .vld_o  (b3_vld),
        .quo_o  (m[j]),
        .den_o  (),
        .side_o (neg3[j])
      );
    end else begin : g_rest
      cfd_div #(.NW(W_NW), .DW(R_W), .SW(1)) u_div (
        .clk_i, .rst_ni, .en_i,
        .vld_i  (b2_vld[j]),
        .num_i  ({w[j][W_NW-3:0], 2'b00}),
        .den_i  (r2[j]),
        .side_i (neg2[j]),
        .vld_o  (),
        .quo_o  (m[j]),
        .den_o  (),
        .side_o (neg3[j])
      );
    end
  end

  // potential sign: centre charge is -2q, outer ones +q
  cfd_div #(.NW(W_NW), .DW(R_W), .SW(1)) u_pdiv (
    .clk_i, .rst_ni, .en_i,
    .vld_i  (b2_vld[0]),
    .num_i  (pot_num),
    .den_i  (r2[0]),
    .side_i (q_i[DATA_W-1] ^ centre_i),
    .vld_o  (),
    .quo_o  (pot_quo),
    .den_o  (),
    .side_o (pot_neg)
  );

  // limit, scale by charge weight, sign
  logic [2:0][W_NW-1:0] lim1;
  logic [2:0][W_NW-1:0] dbl;
  logic [2:0][W_NW-1:0] lim2;
  logic [2:0]           fneg;
  logic [POT_W-1:0]     pot_mag;
  for (genvar j = 0; j < 3; j++) begin : g_clamp
    assign lim1[j] = (m[j] > TERM_LIMIT) ? TERM_LIMIT : m[j];
    assign dbl[j]  = centre_i ? (lim1[j] << 1) : lim1[j];
    assign lim2[j] = (dbl[j] > TERM_LIMIT) ? TERM_LIMIT : dbl[j];
    // outer charges enter the field with -q
    assign fneg[j] = neg3[j] ^ q_i[DATA_W-1] ^ ~centre_i;
  end
  assign pot_mag = {1'b0, pot_quo[POT_W-2:0]};

  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= b3_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pot_o <= pot_neg ? -$signed(pot_mag) : $signed(pot_mag);
      for (int j = 0; j < 3; j++) begin
        fld_o[j] <= fneg[j] ? FLD_W'(-lim2[j]) : lim2[j][FLD_W-1:0];
      end
    end
  end
  assign vld_o = out_vld_q;

endmodule
`default_nettype wire
